// ===== design/mdss_pkg.sv =====
// ----------------------------------------------------------------------------
// mdss_pkg
// Shared words, command format and constants of the duty step sequencer.
// ----------------------------------------------------------------------------
package mdss_pkg;

    localparam int NUM_REGS   = 4;
    localparam int REG_IDX_W  = 2;
    localparam int CNT_W      = 7;
    localparam int DUR_W      = 16;
    localparam int DUTY_W     = 8;
    localparam int TIME_W     = 32;
    localparam int ENTRY_W    = DUR_W + DUTY_W;
    localparam int OUT_DUTIES = 4;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        channel;
        logic [5:0]        step_slot;
        logic [DUR_W-1:0]  step_duration_ms;
        logic [DUTY_W-1:0] step_duty;
    } t_in_word;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_front_left;
        logic [DUTY_W-1:0] duty_front_right;
        logic [DUTY_W-1:0] duty_back_right;
        logic [DUTY_W-1:0] duty_back_left;
        logic              all_finished;
        logic [TIME_W-1:0] next_step_end;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_START,
        CMD_TICK,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              wr_ok;
        logic [1:0]        channel;
        logic [5:0]        slot;
        logic [DUR_W-1:0]  dur;
        logic [DUTY_W-1:0] duty;
    } t_cmd;

endpackage

// ===== design/mdss_ram.sv =====
// ----------------------------------------------------------------------------
// mdss_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mdss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mdss_front.sv =====
// ----------------------------------------------------------------------------
// mdss_front
// Input stage: takes input words, classifies them into commands.
// ----------------------------------------------------------------------------
module mdss_front #(
    parameter int CHANNELS  = 4,
    parameter int MAX_STEPS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mdss_pkg::t_in_word i_in_word,
    output logic               o_push,
    output mdss_pkg::t_cmd     o_cmd,
    input  logic               i_full
);
    import mdss_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.wr_ok   = (32'(i_in_word.channel) < CHANNELS) &&
                        (32'(i_in_word.step_slot) < MAX_STEPS);
        n_cmd.channel = i_in_word.channel;
        n_cmd.slot    = i_in_word.step_slot;
        n_cmd.dur     = i_in_word.step_duration_ms;
        n_cmd.duty    = i_in_word.step_duty;
        case (i_in_word.action)
            ACT_WRITE: n_cmd.kind = CMD_WRITE;
            ACT_START: n_cmd.kind = CMD_START;
            ACT_TICK:  n_cmd.kind = CMD_TICK;
            default:   n_cmd.kind = CMD_NOP;
        endcase
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== design/mdss_queue.sv =====
// ----------------------------------------------------------------------------
// mdss_queue
// Two-entry command queue between the front and back stages.
// ----------------------------------------------------------------------------
module mdss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mdss_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output mdss_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import mdss_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PW     = 1;
    localparam int NW     = 2;

    t_cmd          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic [NW-1:0] n_count;

    assign o_full  = (r_count == NW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== design/mdss_back.sv =====
// ----------------------------------------------------------------------------
// mdss_back
// Sequencer: runs commands over the step table, walks channels, builds result.
// ----------------------------------------------------------------------------
module mdss_back #(
    parameter int CHANNELS  = 4,
    parameter int MAX_STEPS = 64,
    localparam int AW = (CHANNELS * MAX_STEPS > 1) ? $clog2(CHANNELS * MAX_STEPS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mdss_pkg::t_cmd                 i_cmd,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  logic                           i_cfg_we,
    input  logic [mdss_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [mdss_pkg::CNT_W-1:0]     i_cfg_data,
    output logic                           o_ram_we,
    output logic [AW-1:0]                  o_ram_waddr,
    output logic [mdss_pkg::ENTRY_W-1:0]   o_ram_wdata,
    output logic [AW-1:0]                  o_ram_raddr,
    input  logic [mdss_pkg::ENTRY_W-1:0]   i_ram_rdata,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mdss_pkg::t_out_word            o_out_word
);
    import mdss_pkg::*;

    localparam int CW    = $clog2(MAX_STEPS + 1);
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = TIME_W + 1;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_START    = 8'b0000_0010,
        ST_START_WB = 8'b0000_0100,
        ST_ADV      = 8'b0000_1000,
        ST_ADV_WB   = 8'b0001_0000,
        ST_REP_RD   = 8'b0010_0000,
        ST_REP_WB   = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } t_state;

    t_state             r_state,   n_state;
    logic [CHW-1:0]     r_ch,      n_ch;
    logic [CW-1:0]      r_cur      [CHANNELS];
    logic [CW-1:0]      n_cur      [CHANNELS];
    logic [TIME_W-1:0]  r_end      [CHANNELS];
    logic [TIME_W-1:0]  n_end      [CHANNELS];
    logic [TIME_W-1:0]  r_elapsed, n_elapsed;
    logic               r_playing, n_playing;
    logic [CNT_W-1:0]   r_cnt      [NUM_REGS];
    logic               r_any,     n_any;
    logic [TIME_W-1:0]  r_near,    n_near;
    logic [DUTY_W-1:0]  r_duty     [OUT_DUTIES];
    logic [DUTY_W-1:0]  n_duty     [OUT_DUTIES];
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word,  n_out_word;

    logic [CNT_W-1:0]   raw_cnt;
    logic [CW-1:0]      lim;
    logic [CW-1:0]      cur_ch;
    logic [CW-1:0]      cur_nxt;
    logic [TIME_W-1:0]  end_ch;
    logic               pend;
    logic               last_ch;
    logic [DUR_W-1:0]   dur_rd;
    logic [DUTY_W-1:0]  duty_rd;
    logic [SUM_W-1:0]   end_sum;
    logic [SUM_W-1:0]   elapsed_sum;
    logic               out_free;

    function automatic logic [AW-1:0] f_addr(input logic [CHW-1:0] ch,
                                             input logic [CW-1:0] slot);
        return AW'(32'(ch) * 32'(MAX_STEPS) + 32'(slot));
    endfunction

    always_comb begin
        raw_cnt = '0;
        for (int k = 0; k < NUM_REGS; k++) begin
            if (32'(r_ch) == k) begin
                raw_cnt = r_cnt[k];
            end
        end
    end

    assign lim         = (32'(raw_cnt) > MAX_STEPS) ? CW'(MAX_STEPS) : CW'(raw_cnt);
    assign cur_ch      = r_cur[r_ch];
    assign cur_nxt     = cur_ch + CW'(1);
    assign end_ch      = r_end[r_ch];
    assign pend        = r_playing && (cur_ch < lim);
    assign last_ch     = (32'(r_ch) == CHANNELS - 1);
    assign dur_rd      = i_ram_rdata[ENTRY_W-1 -: DUR_W];
    assign duty_rd     = i_ram_rdata[DUTY_W-1:0];
    assign end_sum     = {1'b0, end_ch} + SUM_W'(dur_rd);
    assign elapsed_sum = {1'b0, r_elapsed} + SUM_W'(1);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_ram_waddr = AW'(32'(i_cmd.channel) * 32'(MAX_STEPS) + 32'(i_cmd.slot));
    assign o_ram_wdata = {i_cmd.dur, i_cmd.duty};
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_cur       = r_cur;
        n_end       = r_end;
        n_elapsed   = r_elapsed;
        n_playing   = r_playing;
        n_any       = r_any;
        n_near      = r_near;
        n_duty      = r_duty;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        o_q_pop     = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_raddr = f_addr(r_ch, '0);
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_ch    = '0;
                    n_any   = 1'b0;
                    n_near  = '0;
                    for (int k = 0; k < OUT_DUTIES; k++) begin
                        n_duty[k] = '0;
                    end
                    case (i_cmd.kind)
                        CMD_WRITE: begin
                            o_ram_we = i_cmd.wr_ok;
                            n_state  = ST_REP_RD;
                        end
                        CMD_START: begin
                            n_elapsed = '0;
                            n_playing = 1'b1;
                            n_state   = ST_START;
                        end
                        CMD_TICK: begin
                            if (r_playing) begin
                                n_elapsed = elapsed_sum[SUM_W-1] ? '1
                                                                 : elapsed_sum[TIME_W-1:0];
                                n_state   = ST_ADV;
                            end else begin
                                n_state   = ST_REP_RD;
                            end
                        end
                        default: n_state = ST_REP_RD;
                    endcase
                end
            end
            ST_START: begin
                o_ram_raddr = f_addr(r_ch, '0);
                n_state     = ST_START_WB;
            end
            ST_START_WB: begin
                n_cur[r_ch] = '0;
                n_end[r_ch] = TIME_W'(dur_rd);
                if (last_ch) begin
                    n_ch    = '0;
                    n_state = ST_REP_RD;
                end else begin
                    n_ch    = r_ch + CHW'(1);
                    n_state = ST_START;
                end
            end
            ST_ADV: begin
                if ((cur_ch < lim) && (end_ch < r_elapsed)) begin
                    n_cur[r_ch] = cur_nxt;
                    if (cur_nxt < lim) begin
                        o_ram_raddr = f_addr(r_ch, cur_nxt);
                        n_state     = ST_ADV_WB;
                    end
                end else if (last_ch) begin
                    n_ch    = '0;
                    n_state = ST_REP_RD;
                end else begin
                    n_ch    = r_ch + CHW'(1);
                end
            end
            ST_ADV_WB: begin
                n_end[r_ch] = end_sum[SUM_W-1] ? '1 : end_sum[TIME_W-1:0];
                n_state     = ST_ADV;
            end
            ST_REP_RD: begin
                o_ram_raddr = f_addr(r_ch, pend ? cur_ch : '0);
                n_state     = ST_REP_WB;
            end
            ST_REP_WB: begin
                if (pend) begin
                    for (int k = 0; k < OUT_DUTIES; k++) begin
                        if (32'(r_ch) == k) begin
                            n_duty[k] = duty_rd;
                        end
                    end
                    if (!r_any || (end_ch < r_near)) begin
                        n_near = end_ch;
                    end
                    n_any = 1'b1;
                end
                if (last_ch) begin
                    n_state = ST_OUT;
                end else begin
                    n_ch    = r_ch + CHW'(1);
                    n_state = ST_REP_RD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_word.duty_front_left  = r_duty[0];
                    n_out_word.duty_front_right = r_duty[1];
                    n_out_word.duty_back_right  = r_duty[2];
                    n_out_word.duty_back_left   = r_duty[3];
                    n_out_word.all_finished     = !r_any;
                    n_out_word.next_step_end    = r_any ? r_near : '0;
                    n_state                     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_elapsed   <= '0;
            r_playing   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_cur[k] <= '0;
                r_end[k] <= '0;
            end
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_elapsed   <= n_elapsed;
            r_playing   <= n_playing;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_end       <= n_end;
            if (i_cfg_we) begin
                r_cnt[i_cfg_idx] <= i_cfg_data;
            end
        end
        r_any      <= n_any;
        r_near     <= n_near;
        r_duty     <= n_duty;
        r_out_word <= n_out_word;
    end

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after taking a command");

    a_elapsed_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_q_pop |=> $stable(r_elapsed))
        else $error("elapsed time changed outside command start");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur[r_ch]) <= MAX_STEPS)
        else $error("step index beyond table");

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && out_free |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("result not issued on free output");

endmodule

// ===== design/multichannel_duty_step_sequencer_unit.sv =====
// Path: a write or idle word passes the input register and the command queue, then the
// sequencer reads and reports every channel in turn. A start first loads step 0 of every
// channel; a tick while playing first advances each channel past every ended step.
// Throughput: one word per sequencer pass, while the output is not stalled, bound by the
// single read port of the step table walked one channel per access.
// Reset: synchronous active low; clears counts, timing and control, table content unknown.
// ----------------------------------------------------------------------------
// multichannel_duty_step_sequencer_unit
// Per-channel duty step player: input stage, command queue, table sequencer.
// ----------------------------------------------------------------------------
module multichannel_duty_step_sequencer_unit #(
    parameter int CHANNELS  = 4,
    parameter int MAX_STEPS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mdss_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mdss_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [mdss_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [mdss_pkg::CNT_W-1:0]     i_cfg_data
);
    import mdss_pkg::*;

    localparam int DEPTH = CHANNELS * MAX_STEPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               push;
    t_cmd               front_cmd;
    logic               q_full;
    logic               q_pop;
    t_cmd               q_cmd;
    logic               q_empty;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    mdss_front #(
        .CHANNELS  (CHANNELS),
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_full     (q_full)
    );

    mdss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    mdss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mdss_back #(
        .CHANNELS  (CHANNELS),
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== bench/tb_multichannel_duty_step_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_duty_step_sequencer_unit
// Self-checking bench for the four-channel duty step player. It loads the step
// tables and plays start, tick, write and unused words. Both sides stall at
// random. A cycle-free player in the bench predicts every result word, and
// the monitor compares each field as the word leaves the block.
// ----------------------------------------------------------------------------
module tb_multichannel_duty_step_sequencer_unit;
    import mdss_pkg::*;

    localparam int                CHANNELS      = 4;
    localparam int                MAX_STEPS     = 64;
    localparam logic [1:0]        ACT_UNUSED    = 2'd3;
    localparam int                ITEMS_TARGET  = 1450;
    localparam int                IDLE_LIMIT    = 4000;
    localparam int                SETTLE_CYCLES = 16;
    localparam int                HOLD_CYCLES   = 400;
    localparam logic [TIME_W-1:0] TIME_MAX      = '1;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_word             in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_word            out_word;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx   = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    logic [DUR_W-1:0]  dur_mem  [CHANNELS][MAX_STEPS];
    logic [DUTY_W-1:0] duty_mem [CHANNELS][MAX_STEPS];
    int unsigned       step_idx [CHANNELS] = '{default: 0};
    logic [TIME_W-1:0] end_ms   [CHANNELS] = '{default: '0};
    logic [CNT_W-1:0]  step_cnt [CHANNELS] = '{default: '0};
    logic [TIME_W-1:0] elapsed = '0;
    bit                running = 1'b0;

    t_out_word expected_q[$];
    int        errors       = 0;
    int        words_in     = 0;
    int        results_seen = 0;
    int        starts_sent  = 0;
    int        ticks_sent   = 0;
    int        quiet_cycles = 0;
    int        rx_hold_req  = 0;
    int        rx_left      = 0;
    bit        steady       = 1'b0;

    multichannel_duty_step_sequencer_unit #(
        .CHANNELS  (CHANNELS),
        .MAX_STEPS (MAX_STEPS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic int unsigned steps_of(int ch);
        return (32'(step_cnt[ch]) > MAX_STEPS) ? MAX_STEPS : 32'(step_cnt[ch]);
    endfunction

    function automatic t_out_word play_word(t_in_word w);
        t_out_word         r;
        int unsigned       n;
        logic [DUTY_W-1:0] d [CHANNELS];
        bit                any;
        r   = '0;
        any = 1'b0;
        case (w.action)
            ACT_WRITE: begin
                dur_mem[w.channel][w.step_slot]  = w.step_duration_ms;
                duty_mem[w.channel][w.step_slot] = w.step_duty;
            end
            ACT_START: begin
                elapsed = '0;
                running = 1'b1;
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    step_idx[ch] = 0;
                    end_ms[ch]   = TIME_W'(dur_mem[ch][0]);
                end
            end
            ACT_TICK: begin
                if (running) begin
                    elapsed = sat_sum(elapsed, TIME_W'(1));
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        n = steps_of(ch);
                        while (step_idx[ch] < n && end_ms[ch] < elapsed) begin
                            step_idx[ch]++;
                            if (step_idx[ch] < n)
                                end_ms[ch] = sat_sum(end_ms[ch],
                                                     TIME_W'(dur_mem[ch][step_idx[ch]]));
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int ch = 0; ch < CHANNELS; ch++) begin
            d[ch] = '0;
            if (running && step_idx[ch] < steps_of(ch)) begin
                d[ch] = duty_mem[ch][step_idx[ch]];
                if (!any || end_ms[ch] < r.next_step_end)
                    r.next_step_end = end_ms[ch];
                any = 1'b1;
            end
        end
        r.duty_front_left  = d[0];
        r.duty_front_right = d[1];
        r.duty_back_right  = d[2];
        r.duty_back_left   = d[3];
        r.all_finished     = !any;
        return r;
    endfunction

    function automatic t_in_word make_word(logic [1:0] act, logic [1:0] ch, logic [5:0] slot,
                                           logic [DUR_W-1:0] dur, logic [DUTY_W-1:0] duty);
        t_in_word w;
        w.action           = act;
        w.channel          = ch;
        w.step_slot        = slot;
        w.step_duration_ms = dur;
        w.step_duty        = duty;
        return w;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r = $urandom_range(0, 99);
        if (r < 70)
            return DUR_W'($urandom_range(0, 3));
        if (r < 90)
            return DUR_W'($urandom_range(4, 20));
        return DUR_W'($urandom);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 18)
            return CNT_W'(MAX_STEPS);
        if (r < 24)
            return CNT_W'($urandom_range(MAX_STEPS + 1, 127));
        if (r < 30)
            return CNT_W'(1);
        return CNT_W'($urandom_range(2, 12));
    endfunction

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_word random_entry();
        return make_word(ACT_WRITE, 2'($urandom), 6'($urandom), pick_duration(), 8'($urandom));
    endfunction

    function automatic t_in_word random_control(logic [1:0] act);
        return make_word(act, 2'($urandom), 6'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    task automatic send_word(t_in_word w);
        int pause;
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        expected_q.push_back(play_word(w));
        words_in++;
        if (w.action == ACT_START)
            starts_sent++;
        if (w.action == ACT_TICK)
            ticks_sent++;
        pause = gap_len();
        if (pause > 0) begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_counts(logic [CHANNELS-1:0][CNT_W-1:0] n);
        for (int ch = 0; ch < CHANNELS; ch++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_IDX_W'(ch);
            cfg_data <= n[ch];
            @(posedge i_clk);
            step_cnt[ch] = n[ch];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic play_random_word();
        int r = $urandom_range(0, 99);
        if (r < 72)
            send_word(random_control(ACT_TICK));
        else if (r < 90)
            send_word(random_entry());
        else if (r < 94)
            send_word(random_control(ACT_START));
        else
            send_word(random_control(ACT_UNUSED));
    endtask

    task automatic test_idle_words();
        send_word(random_control(ACT_TICK));
        send_word(random_control(ACT_UNUSED));
        send_word(make_word(ACT_TICK, 2'd3, 6'd63, '1, '1));
    endtask

    task automatic test_table_load();
        steady = 1'b1;
        for (int ch = 0; ch < CHANNELS; ch++)
            for (int s = 0; s < MAX_STEPS; s++)
                send_word(make_word(ACT_WRITE, 2'(ch), 6'(s), pick_duration(), 8'($urandom)));
        steady = 1'b0;
    endtask

    task automatic test_playback_directed();
        settle();
        load_counts({CNT_W'(127), CNT_W'(MAX_STEPS), CNT_W'(0), CNT_W'(3)});
        // zero-length steps up front on channel 0
        send_word(make_word(ACT_WRITE, 2'd0, 6'd0, 16'd0, 8'd10));
        send_word(make_word(ACT_WRITE, 2'd0, 6'd1, 16'd0, 8'd20));
        send_word(make_word(ACT_WRITE, 2'd0, 6'd2, 16'd2, 8'hFF));
        send_word(make_word(ACT_WRITE, 2'd2, 6'd0, 16'hFFFF, 8'hFF));
        send_word(make_word(ACT_WRITE, 2'd3, 6'd0, 16'd1, 8'h00));
        send_word(make_word(ACT_WRITE, 2'd3, 6'd63, 16'd0, 8'h80));
        send_word(random_control(ACT_START));
        repeat (4) send_word(random_control(ACT_TICK));
        // restart while playing
        send_word(random_control(ACT_START));
        send_word(random_control(ACT_TICK));
        // rewrite step 0 of channel 0, already passed after the tick
        send_word(make_word(ACT_WRITE, 2'd0, 6'd0, 16'd5, 8'h00));
        send_word(random_control(ACT_TICK));
        send_word(random_control(ACT_UNUSED));
        send_word(random_control(ACT_TICK));
    endtask

    task automatic test_backpressure();
        settle();
        load_counts({CHANNELS{CNT_W'(MAX_STEPS)}});
        send_word(random_control(ACT_START));
        steady      = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        repeat (60) play_random_word();
        steady = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (20) play_random_word();
        settle();
        repeat (20) play_random_word();
    endtask

    task automatic test_random_sequences(int target);
        logic [CHANNELS-1:0][CNT_W-1:0] counts;
        int phase = 0;
        while (words_in < target) begin
            settle();
            for (int ch = 0; ch < CHANNELS; ch++)
                counts[ch] = (phase == 0) ? '0 :
                             (phase == 1) ? CNT_W'(MAX_STEPS) :
                             (phase == 2) ? '1 : pick_count();
            load_counts(counts);
            steady = (phase % 5 == 3);
            repeat ($urandom_range(0, 8)) send_word(random_entry());
            send_word(random_control(ACT_START));
            repeat ($urandom_range(30, 110)) play_random_word();
            phase++;
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        int r;
        if (rx_hold_req > 0) begin
            rx_left     = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_left > 0) begin
            out_stall <= 1'b1;
            rx_left--;
        end else if (steady) begin
            out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                out_stall <= 1'b0;
            end else if (r < 94) begin
                out_stall <= 1'b1;
                rx_left = $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b1;
                rx_left = $urandom_range(8, 40);
            end
        end
    end

    task automatic compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors < 40)
                $display("%0t %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result word 0x%0h", $time, out_word);
            end else begin
                want = expected_q.pop_front();
                compare_field("duty_front_left", TIME_W'(want.duty_front_left),
                              TIME_W'(out_word.duty_front_left));
                compare_field("duty_front_right", TIME_W'(want.duty_front_right),
                              TIME_W'(out_word.duty_front_right));
                compare_field("duty_back_right", TIME_W'(want.duty_back_right),
                              TIME_W'(out_word.duty_back_right));
                compare_field("duty_back_left", TIME_W'(want.duty_back_left),
                              TIME_W'(out_word.duty_back_left));
                compare_field("all_finished", TIME_W'(want.all_finished),
                              TIME_W'(out_word.all_finished));
                compare_field("next_step_end", want.next_step_end, out_word.next_step_end);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout, %0d result words outstanding", $time, expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_words();
        test_table_load();
        test_playback_directed();
        test_backpressure();
        test_sender_pause();
        test_random_sequences(ITEMS_TARGET);
        settle();
        $display("Played %0d words (%0d starts, %0d ticks), %0d result words checked.",
                 words_in, starts_sent, ticks_sent, results_seen);
        $display("Step counts ran from empty through full and clamped, with stalls on both sides.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== multichannel_duty_step_sequencer_unit.f =====
design/mdss_pkg.sv
design/mdss_ram.sv
design/mdss_front.sv
design/mdss_queue.sv
design/mdss_back.sv
design/multichannel_duty_step_sequencer_unit.sv
bench/tb_multichannel_duty_step_sequencer_unit.sv
